>>> src/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/bbf_pkg.sv
// shared constants and codes for the byte budget fifo
package bbf_pkg;

	localparam int unsigned DEPTH    = 1024;
	localparam int unsigned PTR_W    = $clog2(DEPTH);
	localparam int unsigned ITEM_W   = 11;
	localparam int unsigned BYTES_W  = 32;
	localparam int unsigned OVH_W    = 8;
	localparam int unsigned HANDLE_W = 64;
	localparam int unsigned SIZE_W   = 32;
	localparam int unsigned CHARGE_W = SIZE_W + 1;
	localparam int unsigned TOTAL_W  = 43;
	localparam int unsigned ENTRY_W  = HANDLE_W + CHARGE_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 120;

	localparam logic [OVH_W-1:0] OVH_RESET = OVH_W'(32);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITEMS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD  = 2'd2;

endpackage

>>> src/byte_budget_fifo.sv
// byte budget fifo top level: entry memory, counters, admission and result register
// the input word and the entry memory read are registered first, then the result register loads once the output is free
// a new input word is taken only in the idle state, so each word is committed before the next one is accepted
// a result waiting at the output does not block the next input word
// reset clears pointers, count, byte total, readable mark, limits and output valid; writable mark resets to one
// the entry memory is not cleared and needs no clearing pass
module byte_budget_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [bbf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bbf_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bbf_pkg::IN_DATA_W-1:0]       s_tdata,  // payload_handle, payload_size
	input  logic                                s_tuser,  // opcode
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// popped_handle, item_count, byte_total, readable_flag, writable_flag
	output logic [bbf_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                          m_tuser   // status
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                            state_q;
	logic                              op_s1;
	logic [bbf_pkg::HANDLE_W-1:0]      handle_s1;
	logic [bbf_pkg::CHARGE_W-1:0]      charge_s1;

	logic [bbf_pkg::PTR_W-1:0]         head_q;
	logic [bbf_pkg::PTR_W-1:0]         tail_q;
	logic [bbf_pkg::ITEM_W-1:0]        count_q;
	logic [bbf_pkg::TOTAL_W-1:0]       bytes_q;
	logic                              readable_q;
	logic                              writable_q;

	logic [bbf_pkg::ITEM_W-1:0]        max_items_q;
	logic [bbf_pkg::BYTES_W-1:0]       max_bytes_q;
	logic [bbf_pkg::OVH_W-1:0]         ovh_q;

	logic                              m_tvalid_q;
	logic [1:0]                        m_tuser_q;
	logic [bbf_pkg::OUT_DATA_W-1:0]    m_tdata_q;

	logic                              accept;
	logic                              out_free;
	logic                              commit;
	logic [bbf_pkg::ENTRY_W-1:0]       rd_entry;
	logic [bbf_pkg::HANDLE_W-1:0]      rd_handle;
	logic [bbf_pkg::CHARGE_W-1:0]      rd_charge;
	logic [bbf_pkg::TOTAL_W:0]         sum_bytes;
	logic                              reject;
	logic                              is_push;
	logic                              push_ok;

	logic [bbf_pkg::PTR_W-1:0]         head_d;
	logic [bbf_pkg::PTR_W-1:0]         tail_d;
	logic [bbf_pkg::ITEM_W-1:0]        count_d;
	logic [bbf_pkg::TOTAL_W-1:0]       bytes_d;
	logic                              readable_d;
	logic                              writable_d;
	logic [1:0]                        status_d;
	logic [bbf_pkg::HANDLE_W-1:0]      popped_d;

	// handshake
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == S_EXEC) && out_free;

	// entry memory holds handle and charge per slot
	bbf_ram #(
		.DATA_W (bbf_pkg::ENTRY_W),
		.DEPTH  (bbf_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (commit && push_ok),
		.waddr (tail_q),
		.wdata ({charge_s1, handle_s1}),
		.re    (accept),
		.raddr (head_q),
		.rdata (rd_entry)
	);

	assign rd_handle = rd_entry[bbf_pkg::HANDLE_W-1:0];
	assign rd_charge = rd_entry[bbf_pkg::ENTRY_W-1:bbf_pkg::HANDLE_W];

	// admission test in wide arithmetic
	always_comb begin
		sum_bytes = {1'b0, bytes_q} + (bbf_pkg::TOTAL_W + 1)'(charge_s1);
		reject = 1'b0;
		if ((max_items_q != '0) && (count_q >= max_items_q)) begin
			reject = 1'b1;
		end
		if (count_q >= bbf_pkg::ITEM_W'(bbf_pkg::DEPTH)) begin
			reject = 1'b1;
		end
		if ((max_bytes_q != '0) && (sum_bytes > (bbf_pkg::TOTAL_W + 1)'(max_bytes_q))) begin
			reject = 1'b1;
		end
	end

	assign is_push = (op_s1 == bbf_pkg::OP_PUSH);
	assign push_ok = is_push && !reject;

	// next state of the fifo bookkeeping
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		bytes_d    = bytes_q;
		readable_d = readable_q;
		writable_d = writable_q;
		status_d   = bbf_pkg::ST_DONE;
		popped_d   = '0;
		if (is_push) begin
			if (reject) begin
				writable_d = 1'b0;
				status_d   = bbf_pkg::ST_REJECT;
			end else begin
				if (count_q == '0) begin
					readable_d = 1'b1;
				end
				tail_d  = (tail_q == bbf_pkg::PTR_W'(bbf_pkg::DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_d = count_q + 1'b1;
				bytes_d = sum_bytes[bbf_pkg::TOTAL_W-1:0];
			end
		end else begin
			if (count_q == '0) begin
				status_d = bbf_pkg::ST_EMPTY;
			end else begin
				if (count_q == bbf_pkg::ITEM_W'(1)) begin
					readable_d = 1'b0;
				end
				writable_d = 1'b1;
				popped_d   = rd_handle;
				bytes_d    = bytes_q - bbf_pkg::TOTAL_W'(rd_charge);
				head_d     = (head_q == bbf_pkg::PTR_W'(bbf_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_d    = count_q - 1'b1;
			end
		end
	end

	// sequencer, bookkeeping and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			readable_q  <= 1'b0;
			writable_q  <= 1'b1;
			max_items_q <= '0;
			max_bytes_q <= '0;
			ovh_q       <= bbf_pkg::OVH_RESET;
			m_tvalid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				head_q     <= head_d;
				tail_q     <= tail_d;
				count_q    <= count_d;
				bytes_q    <= bytes_d;
				readable_q <= readable_d;
				writable_q <= writable_d;
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					bbf_pkg::REG_MAX_ITEMS: max_items_q <= cfg_data[bbf_pkg::ITEM_W-1:0];
					bbf_pkg::REG_MAX_BYTES: max_bytes_q <= cfg_data[bbf_pkg::BYTES_W-1:0];
					bbf_pkg::REG_OVERHEAD:  ovh_q <= cfg_data[bbf_pkg::OVH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// input word capture and charge computation
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= s_tuser;
			handle_s1 <= s_tdata[bbf_pkg::HANDLE_W-1:0];
			charge_s1 <= bbf_pkg::CHARGE_W'(s_tdata[bbf_pkg::IN_DATA_W-1:bbf_pkg::HANDLE_W])
				+ bbf_pkg::CHARGE_W'(ovh_q);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			m_tuser_q <= status_d;
			m_tdata_q <= {writable_d, readable_d, bytes_d, count_d, popped_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> src/bbf_ram.sv
// simple dual port ram with registered read data
module bbf_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/bbf_checker.sv
// port level checks for the byte budget fifo
`include "assert_macros.svh"

module bbf_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bbf_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	logic [bbf_pkg::ITEM_W-1:0]   cnt;
	logic [bbf_pkg::HANDLE_W-1:0] popped;
	logic                         readable;
	logic                         empty_st;
	logic                         empty_ok;
	logic                         status_ok;

	assign popped   = m_tdata[bbf_pkg::HANDLE_W-1:0];
	assign cnt      = m_tdata[bbf_pkg::HANDLE_W+bbf_pkg::ITEM_W-1:bbf_pkg::HANDLE_W];
	assign readable = m_tdata[bbf_pkg::OUT_DATA_W-2];

	// status decode
	assign empty_st  = (m_tuser == bbf_pkg::ST_EMPTY);
	assign empty_ok  = (cnt == '0) && (popped == '0);
	assign status_ok = (m_tuser == bbf_pkg::ST_DONE) || (m_tuser == bbf_pkg::ST_REJECT)
		|| (m_tuser == bbf_pkg::ST_EMPTY);

	// a stalled result word holds
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

	// count never exceeds the store depth
	`ASSERT_SAME(a_depth, clk, arst_n, m_tvalid, cnt <= bbf_pkg::ITEM_W'(bbf_pkg::DEPTH))

	// readable mark tracks a non-empty store
	`ASSERT_SAME(a_readable, clk, arst_n, m_tvalid, readable == (cnt != '0))

	// pop on empty reports an empty store and no handle
	`ASSERT_SAME(a_empty, clk, arst_n, m_tvalid && empty_st, empty_ok)

	// only the three status codes appear
	`ASSERT_SAME(a_status, clk, arst_n, m_tvalid, status_ok)

endmodule

bind byte_budget_fifo bbf_port_checks u_bbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> dv/bbf_checker.sv
// checker for the byte budget fifo: tracks the queue contents and compares every result word
module bbf_checker
	import bbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // payload_handle, payload_size
	input  logic                  s_tuser,   // opcode
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// popped_handle, item_count, byte_total, readable_flag, writable_flag
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,   // status
	output int                    errors,
	output int                    outstanding
);

	// bit offsets inside the result word
	localparam int unsigned COUNT_LSB = HANDLE_W;
	localparam int unsigned TOTAL_LSB = COUNT_LSB + ITEM_W;
	localparam int unsigned RD_BIT    = TOTAL_LSB + TOTAL_W;
	localparam int unsigned WR_BIT    = RD_BIT + 1;

	typedef struct {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic [ITEM_W-1:0]     count;
		logic [TOTAL_W-1:0]    total;
		logic                  readable;
		logic                  writable;
	} reply_t;

	// mirrored registers
	logic [ITEM_W-1:0]  lim_items;
	logic [BYTES_W-1:0] lim_bytes;
	logic [OVH_W-1:0]   ovh;

	// mirrored queue contents: handle and the charge taken when it was pushed
	logic [HANDLE_W-1:0] held_handles[$];
	logic [CHARGE_W-1:0] held_charges[$];
	logic [TOTAL_W-1:0]  bytes_now;
	logic                readable_now;
	logic                writable_now;

	// results still to come, oldest first
	reply_t awaited[$];

	// apply one push or pop to the mirrored queue and return the result it gives
	function automatic reply_t admit_or_pop(opcode_t op, logic [HANDLE_W-1:0] handle,
			logic [SIZE_W-1:0] size);
		reply_t r;
		logic [CHARGE_W-1:0] charge;
		logic [TOTAL_W:0] sum;
		logic reject;
		charge = CHARGE_W'(size) + CHARGE_W'(ovh);
		r.status = ST_DONE;
		r.handle = '0;
		if (op == OP_PUSH) begin
			// budget test in one extra bit so nothing wraps
			sum = (TOTAL_W+1)'(bytes_now) + (TOTAL_W+1)'(charge);
			reject = (lim_items != 0 && held_handles.size() >= lim_items)
				|| held_handles.size() >= DEPTH
				|| (lim_bytes != 0 && sum > (TOTAL_W+1)'(lim_bytes));
			if (reject) begin
				writable_now = 1'b0;
				r.status = ST_REJECT;
			end else begin
				if (held_handles.size() == 0)
					readable_now = 1'b1;
				held_handles.push_back(handle);
				held_charges.push_back(charge);
				bytes_now = bytes_now + TOTAL_W'(charge);
			end
		end else begin
			if (held_handles.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				if (held_handles.size() == 1)
					readable_now = 1'b0;
				writable_now = 1'b1;
				r.handle = held_handles.pop_front();
				bytes_now = bytes_now - TOTAL_W'(held_charges.pop_front());
			end
		end
		r.count = ITEM_W'(held_handles.size());
		r.total = bytes_now;
		r.readable = readable_now;
		r.writable = writable_now;
		return r;
	endfunction

	// one field of a result word
	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// watch all three ports at the rising edge
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			lim_items = '0;
			lim_bytes = '0;
			ovh = OVH_RESET;
			held_handles.delete();
			held_charges.delete();
			bytes_now = '0;
			readable_now = 1'b0;
			writable_now = 1'b1;
			awaited.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ITEMS: lim_items = cfg_data[ITEM_W-1:0];
					REG_MAX_BYTES: lim_bytes = cfg_data[BYTES_W-1:0];
					REG_OVERHEAD:  ovh = cfg_data[OVH_W-1:0];
					default: ;
				endcase
			end
			// result word against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, got %0h status %0h",
						$time, m_tdata, m_tuser);
				end else begin
					want = awaited.pop_front();
					check_field("status", 64'(want.status), 64'(m_tuser));
					check_field("popped_handle", want.handle, m_tdata[HANDLE_W-1:0]);
					check_field("item_count", 64'(want.count),
						64'(m_tdata[COUNT_LSB +: ITEM_W]));
					check_field("byte_total", 64'(want.total),
						64'(m_tdata[TOTAL_LSB +: TOTAL_W]));
					check_field("readable_flag", 64'(want.readable), 64'(m_tdata[RD_BIT]));
					check_field("writable_flag", 64'(want.writable), 64'(m_tdata[WR_BIT]));
				end
			end
			// accepted input word
			if (s_tvalid && s_tready)
				awaited.push_back(admit_or_pop(opcode_t'(s_tuser), s_tdata[HANDLE_W-1:0],
					s_tdata[HANDLE_W +: SIZE_W]));
			outstanding = awaited.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// testbench top for the byte budget fifo: clock, reset, stimulus and verdict
module tb_top;
	import bbf_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // payload_handle, payload_size
	logic                  s_tuser = 1'b0; // opcode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// popped_handle, item_count, byte_total, readable_flag, writable_flag
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;        // status
	int                    errors;
	int                    outstanding;
	logic                  s_took = 1'b0;
	logic                  quiet = 1'b0;

	byte_budget_fifo i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	bbf_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// clock
	always #5 clk = ~clk;

	// input word handshake seen at the last rising edge
	always @(posedge clk) begin
		s_took <= s_tvalid && s_tready;
	end

	// result side back-pressure in bursts
	initial begin
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// run limit
	initial begin
		#8000000;
		$display("** byte_budget_fifo: FAILED **");
		$finish;
	end

	// present one word and hold it until taken
	task automatic send_word(input opcode_t op, input logic [HANDLE_W-1:0] handle,
			input logic [SIZE_W-1:0] size);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {size, handle};
		do @(negedge clk); while (s_took !== 1'b1);
	endtask

	task automatic pause_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// let every outstanding result come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [CFG_DATA_W-1:0] items,
			input logic [CFG_DATA_W-1:0] bytes_lim, input logic [CFG_DATA_W-1:0] ovh_val);
		set_reg(REG_MAX_ITEMS, items);
		set_reg(REG_MAX_BYTES, bytes_lim);
		set_reg(REG_OVERHEAD, ovh_val);
	endtask

	// random word with boundary sizes and handles mixed in
	task automatic send_random(input int pop_pct, input logic [SIZE_W-1:0] size_cap,
			input int gap_pct);
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0] size;
		opcode_t op;
		if (!quiet && $urandom_range(0, 99) < gap_pct)
			pause_sender($urandom_range(1, 17));
		op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH;
		case ($urandom_range(0, 15))
			0: handle = '0;
			1: handle = '1;
			default: handle = {$urandom, $urandom};
		endcase
		case ($urandom_range(0, 7))
			0: size = '0;
			1: size = '1;
			2: size = size_cap;
			default: size = $urandom_range(0, size_cap);
		endcase
		send_word(op, handle, size);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limits, overhead of 32
		send_word(OP_POP, '0, '1);
		send_word(OP_PUSH, '1, '1);
		send_word(OP_PUSH, '0, '0);
		send_word(OP_POP, '1, '0);
		send_word(OP_POP, '0, '1);
		send_word(OP_POP, '0, '0);
		drain();

		// item limit of one
		set_limits(1, 0, 0);
		send_word(OP_PUSH, 64'hA5A5_5A5A_0F0F_F0F0, 5);
		send_word(OP_PUSH, 64'h1234_5678_9ABC_DEF0, 5);
		send_word(OP_POP, '0, '0);
		drain();

		// overhead alone exceeds the budget
		set_limits(0, 100, 255);
		send_word(OP_PUSH, 64'h1, 0);
		drain();

		// budget filled exactly, index 3 is not a register
		set_reg(REG_OVERHEAD, 0);
		set_reg(2'd3, '1);
		send_word(OP_PUSH, 64'h2, 100);
		send_word(OP_PUSH, 64'h3, 0);
		send_word(OP_PUSH, 64'h4, 1);
		send_word(OP_POP, '0, '0);
		send_word(OP_POP, '0, '0);
		send_word(OP_POP, '0, '0);
		drain();

		// size plus overhead beyond 32 bits against the widest budget
		set_limits(0, 32'hFFFF_FFFF, 1);
		send_word(OP_PUSH, 64'h5, 32'hFFFF_FFFF);
		send_word(OP_PUSH, 64'h6, 32'hFFFF_FFFE);
		send_word(OP_POP, '0, '0);
		drain();

		// overhead changed while an entry is held
		set_limits(0, 0, 10);
		send_word(OP_PUSH, 64'h7, 3);
		drain();
		set_reg(REG_OVERHEAD, 200);
		send_word(OP_PUSH, 64'h8, 3);
		send_word(OP_POP, '0, '0);
		send_word(OP_POP, '0, '0);
		drain();

		// fill to store depth with an item limit above it, then take some back
		set_limits(11'h7FF, 0, 255);
		repeat (DEPTH + 2) send_random(0, '1, 15);
		repeat (40) send_random(100, '1, 15);
		drain();

		// random phases with different limits, entries carried across phases
		for (int phase = 0; phase < 6; phase++) begin
			int pop_pct;
			int gap_pct;
			logic [SIZE_W-1:0] size_cap;
			case (phase)
				0: begin
					set_limits(0, 0, 32);
					pop_pct = 45; size_cap = 4096; gap_pct = 20;
				end
				1: begin
					set_limits(4, 0, $urandom_range(0, 255));
					pop_pct = 40; size_cap = 1000; gap_pct = 0;
				end
				2: begin
					set_limits(0, $urandom_range(500, 6000), $urandom_range(0, 255));
					pop_pct = 45; size_cap = 1500; gap_pct = 25;
				end
				3: begin
					set_limits(1024, 32'hFFFF_FFFF, 255);
					pop_pct = 30; size_cap = '1; gap_pct = 20;
				end
				4: begin
					set_limits($urandom_range(1, 1024), $urandom, $urandom_range(0, 255));
					pop_pct = 50; size_cap = $urandom; gap_pct = 30;
				end
				default: begin
					set_limits(0, 0, 0);
					quiet = 1'b1;
					pop_pct = 50; size_cap = 2048; gap_pct = 0;
				end
			endcase
			repeat (40) send_random(pop_pct, size_cap, gap_pct);
			drain();
		end

		// stray words after the last expected one
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("** byte_budget_fifo: PASSED **");
		else
			$display("** byte_budget_fifo: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/bbf_pkg.sv
src/bbf_ram.sv
src/byte_budget_fifo.sv
src/bbf_checker.sv
dv/bbf_checker.sv
dv/tb_top.sv
